### rtl/core/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM byte access master.
// Used by i2cee_seq and by the top level i2c_eeprom_byte_access_master.
`default_nettype none

package i2cee_pkg;

    // Request kinds carried with each tick.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
    localparam logic [6:0] DEV_ADDR_RST    = 7'd80;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd255;

    // Bytes of a transaction that end in an acknowledge slot.
    localparam logic [1:0] BYTE_DEV  = 2'd0;
    localparam logic [1:0] BYTE_MEM  = 2'd1;
    localparam logic [1:0] BYTE_LAST = 2'd2;

    // Read/write bit appended below the device address.
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [3:0] BIT_CNT_RESTART = 4'd2;

    typedef enum logic [15:0] {
        S_IDLE       = 16'h0001,
        S_ST_SDA_HI  = 16'h0002,
        S_ST_SCL_HI  = 16'h0004,
        S_ST_SDA_LO  = 16'h0008,
        S_RB_PREP    = 16'h0010,
        S_RB_HI      = 16'h0020,
        S_RB_LO      = 16'h0040,
        S_SP_SDA_LO  = 16'h0080,
        S_SP_SCL_HI  = 16'h0100,
        S_SP_SDA_HI  = 16'h0200,
        S_B_LO       = 16'h0400,
        S_B_SET      = 16'h0800,
        S_B_HI       = 16'h1000,
        S_B_ACK_LO   = 16'h2000,
        S_B_ACK_HI   = 16'h4000,
        S_B_ACK_END  = 16'h8000
    } t_state;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [6:0] device_address;
        logic [7:0] ack_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/i2c_eeprom_byte_access_master.sv
// Top level of the I2C EEPROM byte access master: stream ports, configuration
// registers and the result register. Depends on i2cee_pkg and i2cee_seq.
`default_nettype none

// Tick-driven I2C master for single EEPROM byte writes and random reads. Every
// input word is one timing tick; a word whose kind is byte write or random read
// starts a transaction when the master is idle, and every word returns exactly
// one result word with the SCL and SDA drive levels, busy, a one-tick done flag
// and, on the done tick of a read, the byte read. Words are taken one per clock
// cycle while the output register is free or being drained; an accepted tick's
// result is in the output register in the next cycle. The sequencer state
// advances only on accepted ticks, so the bus timing is set by the tick rate and
// half_period_ticks. The output register lets a new tick enter while the
// previous result is being taken. Configuration writes are always accepted and
// should be issued only while no transaction runs and no result is pending.
module i2c_eeprom_byte_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // mem_address[7:0], write_data[15:8], sda_in[16]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl_level[0], sda_drive[1], busy_res[2],
                                        // done_res[3], read_data[11:4]
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import i2cee_pkg::*;

    t_cfg    r_cfg;
    t_tick   tick;
    t_result seq_res;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;
    logic    cfg_accept;

    // The output register frees up in the same cycle it is drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_accept    = i_cfg_valid && o_cfg_ready;

    assign tick.kind        = s_axis_tuser;
    assign tick.mem_address = s_axis_tdata[7:0];
    assign tick.write_data  = s_axis_tdata[15:8];
    assign tick.sda_in      = s_axis_tdata[16];

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RST;
            r_cfg.device_address    <= DEV_ADDR_RST;
            r_cfg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                CFG_DEV_ADDR:    r_cfg.device_address    <= i_cfg_data[6:0];
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout_ticks <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    i2cee_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_tick  (tick),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    // Result register: loaded with the outcome of every accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= seq_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.read_data, r_out.done_res, r_out.busy_res,
                            r_out.sda_drive, r_out.scl_level};

    // Every accepted tick leaves a result in the output register.
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // The stop completes on the tick that returns the master to idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // An idle master leaves both bus lines released.
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> (r_out.scl_level && r_out.sda_drive))
        else $error("bus line held low while idle");

    // Read data shows only on the done tick.
    a_read_data_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (r_out.read_data == 8'd0))
        else $error("read data outside the done tick");

endmodule

`default_nettype wire

### rtl/core/i2cee_seq.sv
// Bus sequencer of the I2C EEPROM byte access master: state registers and the
// next-state logic for one tick. Depends on i2cee_pkg.
`default_nettype none

module i2cee_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cee_pkg::t_tick   i_tick,
    input  i2cee_pkg::t_cfg    i_cfg,
    output i2cee_pkg::t_result o_res
);
    import i2cee_pkg::*;

    t_state     r_state,     n_state;
    logic [1:0] r_byte_idx,  n_byte_idx;
    logic [3:0] r_bit_cnt,   n_bit_cnt;
    logic [7:0] r_tick_cnt,  n_tick_cnt;
    logic [7:0] r_ack_wait,  n_ack_wait;
    logic [7:0] r_shift,     n_shift;
    logic       r_is_read,   n_is_read;
    logic [7:0] r_held_addr, n_held_addr;
    logic [7:0] r_held_data, n_held_data;
    logic       r_scl,       n_scl;
    logic       r_sda,       n_sda;

    logic [7:0] half_len;
    logic       elapsed;
    logic [3:0] bit_inc;
    logic [7:0] dev_w;
    logic       entering;
    logic       done;
    logic [7:0] rd;

    assign half_len = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign elapsed  = ({1'b0, r_tick_cnt} + 9'd1) >= {1'b0, half_len};
    assign bit_inc  = r_bit_cnt + 4'd1;
    assign dev_w    = {i_cfg.device_address, RW_WRITE};

    always_comb begin
        n_state     = r_state;
        n_byte_idx  = r_byte_idx;
        n_bit_cnt   = r_bit_cnt;
        n_tick_cnt  = r_tick_cnt;
        n_ack_wait  = r_ack_wait;
        n_shift     = r_shift;
        n_is_read   = r_is_read;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_scl       = r_scl;
        n_sda       = r_sda;
        entering    = 1'b0;
        done        = 1'b0;
        rd          = 8'd0;

        // Every timed step counts ticks until its half period has run out.
        if (r_state != S_IDLE && !elapsed) begin
            n_tick_cnt = r_tick_cnt + 8'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_tick.kind == KIND_WRITE || i_tick.kind == KIND_READ) begin
                    n_held_addr = i_tick.mem_address;
                    n_held_data = i_tick.write_data;
                    n_is_read   = (i_tick.kind == KIND_READ);
                    n_bit_cnt   = 4'd0;
                    n_state     = S_ST_SDA_HI;
                    entering    = 1'b1;
                end
            end
            S_ST_SDA_HI: if (elapsed) begin
                n_state  = S_ST_SCL_HI;
                entering = 1'b1;
            end
            S_ST_SCL_HI: if (elapsed) begin
                n_state  = S_ST_SDA_LO;
                entering = 1'b1;
            end
            S_ST_SDA_LO: if (elapsed) begin
                // A bit count of two marks the repeated start of a read.
                n_bit_cnt = 4'd0;
                n_state   = S_B_LO;
                entering  = 1'b1;
                if (r_bit_cnt == BIT_CNT_RESTART) begin
                    n_byte_idx = BYTE_LAST;
                    n_shift    = {i_cfg.device_address, RW_READ};
                end else begin
                    n_byte_idx = BYTE_DEV;
                    n_shift    = dev_w;
                end
            end
            S_RB_PREP: if (elapsed) begin
                n_state  = S_RB_HI;
                entering = 1'b1;
            end
            S_RB_HI: if (elapsed) begin
                n_shift  = {r_shift[6:0], i_tick.sda_in};
                n_state  = S_RB_LO;
                entering = 1'b1;
            end
            S_RB_LO: if (elapsed) begin
                n_bit_cnt = bit_inc;
                n_state   = (bit_inc >= BITS_PER_BYTE) ? S_SP_SDA_LO : S_RB_HI;
                entering  = 1'b1;
            end
            S_SP_SDA_LO: if (elapsed) begin
                n_state  = S_SP_SCL_HI;
                entering = 1'b1;
            end
            S_SP_SCL_HI: if (elapsed) begin
                n_state  = S_SP_SDA_HI;
                entering = 1'b1;
            end
            S_SP_SDA_HI: if (elapsed) begin
                n_state  = S_IDLE;
                entering = 1'b1;
                done     = 1'b1;
                rd       = r_is_read ? r_shift : 8'd0;
            end
            S_B_LO: if (elapsed) begin
                n_state  = S_B_SET;
                entering = 1'b1;
            end
            S_B_SET: if (elapsed) begin
                n_state  = S_B_HI;
                entering = 1'b1;
            end
            S_B_HI: if (elapsed) begin
                n_shift   = {r_shift[6:0], 1'b0};
                n_bit_cnt = bit_inc;
                n_state   = (bit_inc >= BITS_PER_BYTE) ? S_B_ACK_LO : S_B_LO;
                entering  = 1'b1;
            end
            S_B_ACK_LO: if (elapsed) begin
                n_state  = S_B_ACK_HI;
                entering = 1'b1;
            end
            S_B_ACK_HI: if (elapsed) begin
                // Poll once per tick after the first half period.
                if (!i_tick.sda_in || r_ack_wait >= i_cfg.ack_timeout_ticks) begin
                    n_state  = S_B_ACK_END;
                    entering = 1'b1;
                end else begin
                    n_ack_wait = r_ack_wait + 8'd1;
                end
            end
            S_B_ACK_END: if (elapsed) begin
                entering = 1'b1;
                case (r_byte_idx)
                    BYTE_DEV: begin
                        n_bit_cnt  = 4'd0;
                        n_shift    = r_held_addr;
                        n_byte_idx = BYTE_MEM;
                        n_state    = S_B_LO;
                    end
                    BYTE_MEM: begin
                        if (r_is_read) begin
                            n_bit_cnt = BIT_CNT_RESTART;
                            n_state   = S_ST_SDA_HI;
                        end else begin
                            n_bit_cnt  = 4'd0;
                            n_shift    = r_held_data;
                            n_byte_idx = BYTE_LAST;
                            n_state    = S_B_LO;
                        end
                    end
                    BYTE_LAST: begin
                        if (r_is_read) begin
                            n_bit_cnt = 4'd0;
                            n_shift   = 8'd0;
                            n_state   = S_RB_PREP;
                        end else begin
                            n_state = S_SP_SDA_LO;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            default: begin
                n_state  = S_IDLE;
                entering = 1'b1;
            end
        endcase

        // Entry actions of the step just selected.
        if (entering) begin
            n_tick_cnt = 8'd0;
            case (n_state)
                S_IDLE:      begin n_scl = 1'b1; n_sda = 1'b1; end
                S_ST_SDA_HI: n_sda = 1'b1;
                S_ST_SCL_HI: n_scl = 1'b1;
                S_ST_SDA_LO: n_sda = 1'b0;
                S_RB_PREP:   begin n_scl = 1'b0; n_sda = 1'b1; end
                S_RB_HI:     n_scl = 1'b1;
                S_RB_LO:     n_scl = 1'b0;
                S_SP_SDA_LO: n_sda = 1'b0;
                S_SP_SCL_HI: n_scl = 1'b1;
                S_SP_SDA_HI: n_sda = 1'b1;
                S_B_LO:      n_scl = 1'b0;
                S_B_SET:     n_sda = n_shift[7];
                S_B_HI:      n_scl = 1'b1;
                S_B_ACK_LO:  begin n_scl = 1'b0; n_sda = 1'b1; end
                S_B_ACK_HI:  begin n_scl = 1'b1; n_ack_wait = 8'd0; end
                S_B_ACK_END: n_scl = 1'b0;
                default:     begin n_scl = 1'b1; n_sda = 1'b1; end
            endcase
        end
    end

    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_drive = n_sda;
        o_res.busy_res  = (n_state != S_IDLE);
        o_res.done_res  = done;
        o_res.read_data = rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_idx  <= BYTE_DEV;
            r_bit_cnt   <= 4'd0;
            r_tick_cnt  <= 8'd0;
            r_ack_wait  <= 8'd0;
            r_shift     <= 8'd0;
            r_is_read   <= 1'b0;
            r_held_addr <= 8'd0;
            r_held_data <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_step) begin
            r_state     <= n_state;
            r_byte_idx  <= n_byte_idx;
            r_bit_cnt   <= n_bit_cnt;
            r_tick_cnt  <= n_tick_cnt;
            r_ack_wait  <= n_ack_wait;
            r_shift     <= n_shift;
            r_is_read   <= n_is_read;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

endmodule

`default_nettype wire
